// ===== src/dram_bank_scheduler_assert.svh =====
// Assertion macros shared by the bank scheduler RTL.
`ifndef DRAM_BANK_SCHEDULER_ASSERT_SVH
`define DRAM_BANK_SCHEDULER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dbs_pkg.sv =====
// Types and constants of the DRAM bank scheduler.
package dbs_pkg;

  // Geometry, fixed by the widths of the rank and bank index fields.
  localparam int unsigned NUM_RANKS  = 4;
  localparam int unsigned NUM_BANKS  = 8;
  localparam int unsigned SLOTS      = NUM_RANKS * NUM_BANKS;
  localparam int unsigned RANK_W     = 2;
  localparam int unsigned BANK_W     = 3;
  localparam int unsigned RANK_CNT_W = 3;
  localparam int unsigned BANK_CNT_W = 4;
  localparam int unsigned CYCLE_BITS = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BANKS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANKS  = 2'd2;

  localparam logic [BANK_CNT_W-1:0] BANKS_RESET = 4'd8;
  localparam logic [RANK_CNT_W-1:0] RANKS_RESET = 3'd1;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_FIND   = 1'b1
  } opcode_e;

  typedef enum logic {
    POL_ROUND_ROBIN = 1'b0,
    POL_OLDEST      = 1'b1
  } policy_e;

  // Search settings, to be kept steady by the user for the whole of one find; the block does not enforce it.
  typedef struct packed {
    logic                  oldest;
    logic [BANK_CNT_W-1:0] banks_used;
    logic [RANK_CNT_W-1:0] ranks_used;
    logic [RANK_W-1:0]     first_rank;
    logic [BANK_W-1:0]     first_bank;
  } scan_ctrl_t;

  // One bank status update.
  typedef struct packed {
    logic              en;
    logic [RANK_W-1:0] rank;
    logic [BANK_W-1:0] bank;
    logic              pending;
  } upd_t;

  // Best candidate so far, handed from cell to cell with the search wave.
  typedef struct packed {
    logic              wave;
    logic              hit;
    logic [RANK_W-1:0] rank;
    logic [BANK_W-1:0] bank;
  } cand_t;

endpackage

// ===== src/dbs_cell.sv =====
// One bank slot of the scheduler: status storage and one compare stage.
module dbs_cell #(
  parameter int unsigned CycleBits = dbs_pkg::CYCLE_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dbs_pkg::RANK_W-1:0] slot_rank_i,
  input  logic [dbs_pkg::BANK_W-1:0] slot_bank_i,
  input  dbs_pkg::upd_t             upd_i,
  input  logic [CycleBits-1:0]      upd_front_i,
  input  dbs_pkg::scan_ctrl_t       ctrl_i,
  input  dbs_pkg::cand_t            cand_i,
  input  logic [CycleBits-1:0]      key_i,
  output dbs_pkg::cand_t            cand_o,
  output logic [CycleBits-1:0]      key_o
);

  logic                 pend_q;
  logic [CycleBits-1:0] front_q;
  logic                 upd_hit;
  logic                 in_use;
  logic                 wrapped;
  logic                 take;
  logic [CycleBits-1:0] my_key;
  dbs_pkg::cand_t       cand_d, cand_q;
  logic [CycleBits-1:0] key_d, key_q;

  // Status storage, written by an update item that names this slot.
  assign upd_hit = upd_i.en && (upd_i.rank == slot_rank_i) && (upd_i.bank == slot_bank_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (upd_hit) begin
      pend_q <= upd_i.pending;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_hit) begin
      front_q <= upd_front_i;
    end
  end

  // A slot outside the banks and ranks in use keeps its flag but never wins.
  assign in_use = pend_q
                  && ({1'b0, slot_bank_i} < ctrl_i.banks_used)
                  && ({1'b0, slot_rank_i} < ctrl_i.ranks_used);

  // In round robin the slots before the first looked-at bank come last.
  assign wrapped = (slot_rank_i < ctrl_i.first_rank)
                   || ((slot_rank_i == ctrl_i.first_rank) && (slot_bank_i < ctrl_i.first_bank));

  assign my_key = ctrl_i.oldest ? front_q : {{(CycleBits-1){1'b0}}, wrapped};

  // Strict compare: an earlier slot keeps a tie.
  assign take = in_use && (!cand_i.hit || (my_key < key_i));

  always_comb begin
    cand_d      = cand_i;
    key_d       = key_i;
    if (take) begin
      cand_d.hit  = 1'b1;
      cand_d.rank = slot_rank_i;
      cand_d.bank = slot_bank_i;
      key_d       = my_key;
    end
  end

  // Hand the candidate to the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign cand_o = cand_q;
  assign key_o  = key_q;

endmodule

// ===== src/dram_bank_scheduler.sv =====
// Top level of the DRAM bank scheduler: registers, pointer and the cell chain.
// An update item is accepted only while busy is low; updates may be started in consecutive cycles.
// A find item travels the chain of 32 bank cells, one cell a cycle: busy is high while
// the wave is in the chain, and done_o strobes from its register as busy drops.
// The next item may start in the cycle of the done_o strobe; the receiver cannot stall.
// Reset clears all pending flags and the round-robin pointer and restores register defaults.
// Front cycles are not cleared; they are only read once their bank has been written.
module dram_bank_scheduler #(
  parameter int unsigned CycleBits = dbs_pkg::CYCLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [dbs_pkg::RANK_W-1:0]     rank_index_i,
  input  logic [dbs_pkg::BANK_W-1:0]     bank_index_i,
  input  logic                           has_commands_i,
  input  logic [CycleBits-1:0]           front_cycle_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [dbs_pkg::RANK_W-1:0]     chosen_rank_o,
  output logic [dbs_pkg::BANK_W-1:0]     chosen_bank_o,
  input  logic                           cfg_we_i,
  input  logic [dbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  `include "dram_bank_scheduler_assert.svh"

  dbs_pkg::policy_e                   policy_q;
  logic [dbs_pkg::BANK_CNT_W-1:0]     banks_q;
  logic [dbs_pkg::RANK_CNT_W-1:0]     ranks_q;
  logic [dbs_pkg::RANK_W-1:0]         rr_rank_q, rr_rank_d;
  logic [dbs_pkg::BANK_W-1:0]         rr_bank_q, rr_bank_d;
  logic                               busy_q, busy_d;
  logic                               done_q;
  logic                               found_q;
  logic [dbs_pkg::RANK_W-1:0]         chosen_rank_q;
  logic [dbs_pkg::BANK_W-1:0]         chosen_bank_q;

  logic                               accept;
  logic                               find_go;
  logic                               scan_end;
  logic [dbs_pkg::BANK_CNT_W-1:0]     banks_used;
  logic [dbs_pkg::RANK_CNT_W-1:0]     ranks_used;
  logic [dbs_pkg::BANK_CNT_W-1:0]     bank_inc;
  logic [dbs_pkg::RANK_CNT_W-1:0]     rank_tmp;
  logic [dbs_pkg::RANK_W-1:0]         first_rank;
  logic [dbs_pkg::BANK_W-1:0]         first_bank;
  logic [dbs_pkg::RANK_W-1:0]         back_rank;
  logic [dbs_pkg::BANK_W-1:0]         back_bank;

  dbs_pkg::scan_ctrl_t                ctrl;
  dbs_pkg::upd_t                      upd;
  dbs_pkg::cand_t                     cand [0:dbs_pkg::SLOTS];
  logic [CycleBits-1:0]               key  [0:dbs_pkg::SLOTS];

  // Item handshake.
  assign accept  = start && !busy_q;
  assign find_go = accept && (opcode_i == dbs_pkg::OP_FIND);
  assign busy    = busy_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= dbs_pkg::POL_ROUND_ROBIN;
      banks_q  <= dbs_pkg::BANKS_RESET;
      ranks_q  <= dbs_pkg::RANKS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dbs_pkg::REG_POLICY: policy_q <= dbs_pkg::policy_e'(cfg_data_i[0]);
        dbs_pkg::REG_BANKS:  banks_q  <= cfg_data_i[dbs_pkg::BANK_CNT_W-1:0];
        dbs_pkg::REG_RANKS:  ranks_q  <= cfg_data_i[dbs_pkg::RANK_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Counts in use: zero counts as one, anything above the maximum as the maximum.
  always_comb begin
    if (banks_q == '0) begin
      banks_used = dbs_pkg::BANK_CNT_W'(1);
    end else if (banks_q > dbs_pkg::BANK_CNT_W'(dbs_pkg::NUM_BANKS)) begin
      banks_used = dbs_pkg::BANK_CNT_W'(dbs_pkg::NUM_BANKS);
    end else begin
      banks_used = banks_q;
    end
    if (ranks_q == '0) begin
      ranks_used = dbs_pkg::RANK_CNT_W'(1);
    end else if (ranks_q > dbs_pkg::RANK_CNT_W'(dbs_pkg::NUM_RANKS)) begin
      ranks_used = dbs_pkg::RANK_CNT_W'(dbs_pkg::NUM_RANKS);
    end else begin
      ranks_used = ranks_q;
    end
  end

  // First bank looked at: one step on from the pointer, bank first, then rank.
  always_comb begin
    bank_inc = {1'b0, rr_bank_q} + dbs_pkg::BANK_CNT_W'(1);
    if (bank_inc >= banks_used) begin
      first_bank = '0;
      rank_tmp   = {1'b0, rr_rank_q} + dbs_pkg::RANK_CNT_W'(1);
    end else begin
      first_bank = bank_inc[dbs_pkg::BANK_W-1:0];
      rank_tmp   = {1'b0, rr_rank_q};
    end
    if (rank_tmp >= ranks_used) begin
      first_rank = '0;
    end else begin
      first_rank = rank_tmp[dbs_pkg::RANK_W-1:0];
    end
  end

  // After a full loop without a hit the pointer rests one step before the first bank.
  always_comb begin
    if (first_bank == '0) begin
      back_bank = dbs_pkg::BANK_W'(banks_used - dbs_pkg::BANK_CNT_W'(1));
      if (first_rank == '0) begin
        back_rank = dbs_pkg::RANK_W'(ranks_used - dbs_pkg::RANK_CNT_W'(1));
      end else begin
        back_rank = first_rank - dbs_pkg::RANK_W'(1);
      end
    end else begin
      back_bank = first_bank - dbs_pkg::BANK_W'(1);
      back_rank = first_rank;
    end
  end

  assign ctrl.oldest     = (policy_q == dbs_pkg::POL_OLDEST);
  assign ctrl.banks_used = banks_used;
  assign ctrl.ranks_used = ranks_used;
  assign ctrl.first_rank = first_rank;
  assign ctrl.first_bank = first_bank;

  assign upd.en      = accept && (opcode_i == dbs_pkg::OP_UPDATE);
  assign upd.rank    = rank_index_i;
  assign upd.bank    = bank_index_i;
  assign upd.pending = has_commands_i;

  // The search wave enters the chain with no candidate.
  assign cand[0].wave = find_go;
  assign cand[0].hit  = 1'b0;
  assign cand[0].rank = '0;
  assign cand[0].bank = '0;
  assign key[0]       = '0;

  // Chain of bank cells in flat rank-major order.
  for (genvar s = 0; s < dbs_pkg::SLOTS; s++) begin : g_cell
    dbs_cell #(
      .CycleBits (CycleBits)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .slot_rank_i (dbs_pkg::RANK_W'(s / dbs_pkg::NUM_BANKS)),
      .slot_bank_i (dbs_pkg::BANK_W'(s % dbs_pkg::NUM_BANKS)),
      .upd_i       (upd),
      .upd_front_i (front_cycle_i),
      .ctrl_i      (ctrl),
      .cand_i      (cand[s]),
      .key_i       (key[s]),
      .cand_o      (cand[s+1]),
      .key_o       (key[s+1])
    );
  end

  assign scan_end = cand[dbs_pkg::SLOTS].wave;

  // Busy flag and round-robin pointer.
  always_comb begin
    busy_d    = busy_q;
    rr_rank_d = rr_rank_q;
    rr_bank_d = rr_bank_q;
    if (find_go) begin
      busy_d = 1'b1;
    end
    if (scan_end) begin
      busy_d = 1'b0;
      if (!ctrl.oldest) begin
        if (cand[dbs_pkg::SLOTS].hit) begin
          rr_rank_d = cand[dbs_pkg::SLOTS].rank;
          rr_bank_d = cand[dbs_pkg::SLOTS].bank;
        end else begin
          rr_rank_d = back_rank;
          rr_bank_d = back_bank;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      rr_rank_q <= '0;
      rr_bank_q <= '0;
      done_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      rr_rank_q <= rr_rank_d;
      rr_bank_q <= rr_bank_d;
      done_q    <= scan_end;
    end
  end

  // Result registers; a miss reports rank and bank zero.
  always_ff @(posedge clk_i) begin
    if (scan_end) begin
      found_q       <= cand[dbs_pkg::SLOTS].hit;
      chosen_rank_q <= cand[dbs_pkg::SLOTS].hit ? cand[dbs_pkg::SLOTS].rank : '0;
      chosen_bank_q <= cand[dbs_pkg::SLOTS].hit ? cand[dbs_pkg::SLOTS].bank : '0;
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign chosen_rank_o = chosen_rank_q;
  assign chosen_bank_o = chosen_bank_q;

  // Checks on the find sequencing and the pointer.
  `DBS_ASSERT_NEXT(a_find_sets_busy, clk_i, rst_ni, find_go, busy_q,
    "find item accepted but block not busy")
  `DBS_ASSERT_NOW(a_wave_only_busy, clk_i, rst_ni, !busy_q, !scan_end,
    "search wave left the chain while idle")
  `DBS_ASSERT_NEXT(a_end_gives_done, clk_i, rst_ni, scan_end, done_q && !busy_q,
    "search ended without a result strobe")
  `DBS_ASSERT_NOW(a_miss_is_zero, clk_i, rst_ni, done_q && !found_q,
    (chosen_rank_q == '0) && (chosen_bank_q == '0), "miss reported a bank")
  `DBS_ASSERT_NOW(a_rr_pointer_hit, clk_i, rst_ni, done_q && found_q && !ctrl.oldest,
    (rr_rank_q == chosen_rank_q) && (rr_bank_q == chosen_bank_q),
    "round-robin pointer does not rest on the chosen bank")

endmodule
